// ===== hw/rtl/bcu_pkg.sv =====
// Barycentric coordinate unit: shared widths, types and arithmetic helpers.
// Used by barycentric_coordinate_unit. No dependencies.
`default_nettype none

package bcu_pkg;

  localparam int COORD_BITS       = 24;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 4;
  localparam int LIMIT_W          = 62;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(282);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DOT_W  = PROD_W + 1;
  localparam int LO_W   = (DOT_W + 1) / 2;
  localparam int HI_W   = DOT_W - LO_W;
  localparam int WIDE_W = 2 * DOT_W + 2;
  // quotient carries one extra bit below the weight LSB for rounding
  localparam int Q2_BITS = WEIGHT_BITS + 1;
  localparam int REM_W   = WIDE_W + Q2_BITS;

  // pipeline stage positions
  localparam int ST_DIFF = 0;
  localparam int ST_PROD = 1;
  localparam int ST_DOT  = 2;
  localparam int ST_PART = 3;
  localparam int ST_WIDE = 4;
  localparam int ST_NUM  = 5;
  localparam int ST_SIGN = 6;
  localparam int ST_MAG  = 7;
  localparam int ST_INIT = 8;
  localparam int ST_OUT  = ST_INIT + Q2_BITS + 1;
  localparam int NST     = ST_OUT + 1;

  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [DOT_W-1:0]       dot_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;

  localparam weight_t W_MAX   = weight_t'((64'sd1 <<< (WEIGHT_BITS - 1)) - 1);
  localparam weight_t W_MIN   = weight_t'(-(64'sd1 <<< (WEIGHT_BITS - 1)));
  localparam weight_t W_THIRD = weight_t'(((64'sd1 <<< WEIGHT_FRAC_BITS) + 1) / 3);

  typedef struct packed {
    logic        [2*LO_W-1:0]      ll;
    logic signed [LO_W+HI_W:0]     lh;
    logic signed [LO_W+HI_W:0]     hl;
    logic signed [2*HI_W-1:0]      hh;
  } parts_t;

  typedef struct packed {
    logic [2:0][REM_W-1:0]   rem;
    logic [2:0][Q2_BITS-1:0] quo;
    logic [2:0]              neg;
    logic [2:0]              ovf;
    logic [WIDE_W-1:0]       den;
    logic                    deg;
  } div_t;

  // split a wide signed product into four narrow partial products
  function automatic parts_t mul_split(dot_t a, dot_t b);
    parts_t                 p;
    logic [LO_W-1:0]        al, bl;
    logic signed [HI_W-1:0] ah, bh;
    al = a[LO_W-1:0];
    bl = b[LO_W-1:0];
    ah = a[DOT_W-1:LO_W];
    bh = b[DOT_W-1:LO_W];
    p.ll = al * bl;
    p.lh = $signed({1'b0, al}) * bh;
    p.hl = ah * $signed({1'b0, bl});
    p.hh = ah * bh;
    return p;
  endfunction

  function automatic wide_t mul_join(parts_t p);
    return (wide_t'(p.hh) <<< (2 * LO_W))
         + ((wide_t'(p.lh) + wide_t'(p.hl)) <<< LO_W)
         + wide_t'(p.ll);
  endfunction

  // round half away from zero, then saturate to the weight range
  function automatic weight_t sat_weight(logic [Q2_BITS-1:0] q2, logic neg, logic ovf);
    logic [WEIGHT_BITS:0] q;
    weight_t              w;
    q = {1'b0, q2[Q2_BITS-1:1]} + (WEIGHT_BITS+1)'(q2[0]);
    if (neg) begin
      if (ovf || q > (WEIGHT_BITS+1)'(1 << (WEIGHT_BITS - 1))) w = W_MIN;
      else w = weight_t'(-q);
    end else begin
      if (ovf || q > (WEIGHT_BITS+1)'(W_MAX)) w = W_MAX;
      else w = weight_t'(q);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/barycentric_coordinate_unit.sv =====
// Barycentric coordinate unit: top level, full datapath pipeline.
// Depends on bcu_pkg.
//
// Takes one point/triangle beat per cycle while in_stall_o is low and returns
// one weight beat per beat, in order. The depth is set by the divider: one
// restoring quotient bit per stage, 21 stages for all three weights side by
// side, behind an alignment and overflow stage and ahead of the output
// register, after eight stages of differences, dot products, split 51x51
// products and the determinant. Empty stages close up under output stall, so
// input is still taken while a result waits. The degenerate limit is sampled
// mid-pipe; write it only with the unit drained.
`default_nettype none

module barycentric_coordinate_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] point_x_i,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] point_y_i,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] point_z_i,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] corner_a_x_i,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] corner_a_y_i,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] corner_a_z_i,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] corner_b_x_i,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] corner_b_y_i,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] corner_b_z_i,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] corner_c_x_i,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] corner_c_y_i,
  input  wire logic signed [bcu_pkg::COORD_BITS-1:0] corner_c_z_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic signed [bcu_pkg::WEIGHT_BITS-1:0] weight_a_o,
  output      logic signed [bcu_pkg::WEIGHT_BITS-1:0] weight_b_o,
  output      logic signed [bcu_pkg::WEIGHT_BITS-1:0] weight_c_o,
  output      logic                          degenerate_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [bcu_pkg::LIMIT_W-1:0]   cfg_data_i
);
  import bcu_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic [NST-1:0]     v_q;
  logic [NST:0]       en;

  diff_t  e_q  [3][3];   // [vector: e0, e1, ep][axis]
  prod_t  pr_q [5][3];
  dot_t   d_q  [5];      // d00, d01, d11, d20, d21
  parts_t pt_q [6];
  wide_t  w_q  [6];
  wide_t  det_q, nb_q, nc_q;
  wide_t  n_s_q [3];
  logic   det_neg_q;
  logic [WIDE_W-1:0] den_s_q;
  logic [WIDE_W-1:0] mag_q [3];
  logic [2:0]        neg_q;
  logic              deg_q;
  logic [WIDE_W-1:0] den_m_q;
  div_t   div_d [Q2_BITS+1];
  div_t   div_q [Q2_BITS+1];
  weight_t wa_q, wb_q, wc_q;
  logic    dg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    en[NST] = !out_stall_i;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_DIFF]) begin
      e_q[0][0] <= diff_t'(corner_b_x_i) - diff_t'(corner_a_x_i);
      e_q[0][1] <= diff_t'(corner_b_y_i) - diff_t'(corner_a_y_i);
      e_q[0][2] <= diff_t'(corner_b_z_i) - diff_t'(corner_a_z_i);
      e_q[1][0] <= diff_t'(corner_c_x_i) - diff_t'(corner_a_x_i);
      e_q[1][1] <= diff_t'(corner_c_y_i) - diff_t'(corner_a_y_i);
      e_q[1][2] <= diff_t'(corner_c_z_i) - diff_t'(corner_a_z_i);
      e_q[2][0] <= diff_t'(point_x_i) - diff_t'(corner_a_x_i);
      e_q[2][1] <= diff_t'(point_y_i) - diff_t'(corner_a_y_i);
      e_q[2][2] <= diff_t'(point_z_i) - diff_t'(corner_a_z_i);
    end
    if (en[ST_PROD]) begin
      for (int j = 0; j < 3; j++) begin
        pr_q[0][j] <= e_q[0][j] * e_q[0][j];
        pr_q[1][j] <= e_q[0][j] * e_q[1][j];
        pr_q[2][j] <= e_q[1][j] * e_q[1][j];
        pr_q[3][j] <= e_q[2][j] * e_q[0][j];
        pr_q[4][j] <= e_q[2][j] * e_q[1][j];
      end
    end
    if (en[ST_DOT]) begin
      for (int i = 0; i < 5; i++) begin
        d_q[i] <= dot_t'(pr_q[i][0]) + dot_t'(pr_q[i][1]) + dot_t'(pr_q[i][2]);
      end
    end
    if (en[ST_PART]) begin
      pt_q[0] <= mul_split(d_q[0], d_q[2]);
      pt_q[1] <= mul_split(d_q[1], d_q[1]);
      pt_q[2] <= mul_split(d_q[2], d_q[3]);
      pt_q[3] <= mul_split(d_q[1], d_q[4]);
      pt_q[4] <= mul_split(d_q[0], d_q[4]);
      pt_q[5] <= mul_split(d_q[1], d_q[3]);
    end
    if (en[ST_WIDE]) begin
      for (int i = 0; i < 6; i++) begin
        w_q[i] <= mul_join(pt_q[i]);
      end
    end
    if (en[ST_NUM]) begin
      det_q <= w_q[0] - w_q[1];
      nb_q  <= w_q[2] - w_q[3];
      nc_q  <= w_q[4] - w_q[5];
    end
    if (en[ST_SIGN]) begin
      n_s_q[0]  <= det_q - nb_q - nc_q;
      n_s_q[1]  <= nb_q;
      n_s_q[2]  <= nc_q;
      det_neg_q <= det_q[WIDE_W-1];
      den_s_q   <= det_q[WIDE_W-1] ? WIDE_W'(-det_q) : WIDE_W'(det_q);
    end
    if (en[ST_MAG]) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= n_s_q[i][WIDE_W-1] ? WIDE_W'(-n_s_q[i]) : WIDE_W'(n_s_q[i]);
        neg_q[i] <= n_s_q[i][WIDE_W-1] ^ det_neg_q;
      end
      deg_q   <= (den_s_q == '0) || (den_s_q < WIDE_W'(limit_q));
      den_m_q <= den_s_q;
    end
  end

  // overflow check, then one restoring quotient bit per stage, MSB first
  always_comb begin
    div_d[0].den = den_m_q;
    div_d[0].deg = deg_q;
    div_d[0].neg = neg_q;
    div_d[0].quo = '0;
    for (int l = 0; l < 3; l++) begin
      // ratio of 16 or more does not fit the quotient
      div_d[0].ovf[l] = {4'b0000, mag_q[l]} >= {den_m_q, 4'b0000};
      div_d[0].rem[l] = REM_W'(mag_q[l]) << (Q2_BITS - WEIGHT_BITS + WEIGHT_FRAC_BITS);
    end
    for (int i = 0; i < Q2_BITS; i++) begin
      div_d[i+1] = div_q[i];
      for (int l = 0; l < 3; l++) begin
        if (div_q[i].rem[l] >= (REM_W'(div_q[i].den) << (Q2_BITS - 1 - i))) begin
          div_d[i+1].rem[l] = div_q[i].rem[l] - (REM_W'(div_q[i].den) << (Q2_BITS - 1 - i));
          div_d[i+1].quo[l][Q2_BITS-1-i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= Q2_BITS; i++) begin
      if (en[ST_INIT+i]) div_q[i] <= div_d[i];
    end
    if (en[ST_OUT]) begin
      dg_q <= div_q[Q2_BITS].deg;
      if (div_q[Q2_BITS].deg) begin
        wa_q <= W_THIRD;
        wb_q <= W_THIRD;
        wc_q <= W_THIRD;
      end else begin
        wa_q <= sat_weight(div_q[Q2_BITS].quo[0], div_q[Q2_BITS].neg[0], div_q[Q2_BITS].ovf[0]);
        wb_q <= sat_weight(div_q[Q2_BITS].quo[1], div_q[Q2_BITS].neg[1], div_q[Q2_BITS].ovf[1]);
        wc_q <= sat_weight(div_q[Q2_BITS].quo[2], div_q[Q2_BITS].neg[2], div_q[Q2_BITS].ovf[2]);
      end
    end
  end

  assign out_valid_o  = v_q[ST_OUT];
  assign weight_a_o   = wa_q;
  assign weight_b_o   = wb_q;
  assign weight_c_o   = wc_q;
  assign degenerate_o = dg_q;

  a_deg_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      weight_a_o == W_THIRD && weight_b_o == W_THIRD && weight_c_o == W_THIRD)
    else $error("degenerate beat without one-third weights");

  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[ST_DIFF])
    else $error("accepted beat lost at pipeline entry");

endmodule

`default_nettype wire
